@@ rtl/core/mie_pkg.sv @@
package mie_pkg;

    // Word and memory geometry.
    localparam int WORD_W        = 12;
    localparam int MEM_WORDS_DEF = 4096;

    typedef logic [WORD_W-1:0] word_t;

    localparam word_t RESET_PC  = 12'd128;
    localparam word_t PAGE_MASK = 12'(((1 << 5) - 1) << 7);

    // Pointers at octal 0010 through 0017 autoindex when used indirectly.
    localparam logic [8:0] AUTO_PAGE = 9'd1;

    // Opcodes of the decoded instruction.
    localparam logic [3:0] OP_AND   = 4'd0;
    localparam logic [3:0] OP_TAD   = 4'd1;
    localparam logic [3:0] OP_ISZ   = 4'd2;
    localparam logic [3:0] OP_DCA   = 4'd3;
    localparam logic [3:0] OP_JMS   = 4'd4;
    localparam logic [3:0] OP_JMP   = 4'd5;
    localparam logic [3:0] OP_IOT   = 4'd6;
    localparam logic [3:0] OP_OPR   = 4'd7;
    localparam logic [3:0] OP_DEP   = 4'd8;
    localparam logic [3:0] OP_SETPC = 4'd9;
    localparam logic [3:0] OP_EXAM  = 4'd10;

    // One instruction beat.
    typedef struct packed {
        logic [3:0] opcode;
        logic       indirect;
        logic       current_page;
        logic [6:0] page_offset;
        word_t      load_address;
        word_t      load_data;
    } instr_t;

    // One result beat.
    typedef struct packed {
        word_t acc_out;
        logic  link_out;
        word_t pc_out;
        logic  skip_taken;
        word_t mem_data;
    } result_t;

    // Group-2 skip condition; the micro bits are instruction bits 5 to 11.
    function automatic logic g2_skip(logic [6:0] micro, word_t acc, logic link);
        logic neg;
        logic zero;
        logic hit;
        neg  = acc[WORD_W-1];
        zero = (acc == '0);
        if (micro[3])
        begin
            hit = (!micro[6] || !neg) && (!micro[5] || !zero) && (!micro[4] || !link);
        end
        else
        begin
            hit = (micro[6] && neg) || (micro[5] && zero) || (micro[4] && link);
        end
        return hit;
    endfunction

endpackage

@@ rtl/core/mie_ram.sv @@
module mie_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port: a write, or a read whose data is registered and held.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/mie_exec.sv @@
module mie_exec
    import mie_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  instr_t  item,
    output logic    item_pop,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int          AW        = $clog2(MEM_WORDS);
    localparam logic [12:0] MEM_LIMIT = 13'(MEM_WORDS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_IND,
        S_EXEC,
        S_OPRD,
        S_EXAM
    } state_t;

    state_t     state_reg, state_next;
    word_t      acc_reg, acc_next;
    logic       link_reg, link_next;
    word_t      pc_reg, pc_next;
    logic [3:0] op_reg, op_next;
    word_t      ptr_reg, ptr_next;
    word_t      ea_reg, ea_next;
    logic       rd_zero_reg, rd_zero_next;
    logic       res_valid_reg;
    result_t    res_reg;

    logic       mem_en;
    logic       mem_we;
    word_t      mem_addr;
    word_t      mem_wdata;
    word_t      ram_rdata;

    logic       out_free;
    logic       res_load;
    logic       res_skip;
    word_t      res_mdata;
    word_t      rd_word;
    word_t      ptr;
    word_t      pc_inc;
    word_t      inc_word;
    logic [12:0] tad_sum;
    logic       opnd_go;
    logic [3:0] opnd_op;
    word_t      opnd_ea;
    logic       opr_g2;

    function automatic logic in_range(word_t a);
        return {1'b0, a} < MEM_LIMIT;
    endfunction

    mie_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MEM_WORDS)
    ) u_ram (
        .clk   (clk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr[AW-1:0]),
        .wdata (mem_wdata),
        .rdata (ram_rdata)
    );

    assign out_free = !res_valid_reg || !result_stall;
    assign rd_word  = rd_zero_reg ? '0 : ram_rdata;
    assign ptr      = ({WORD_W{item.current_page}} & (pc_reg & PAGE_MASK))
                    | {5'b0, item.page_offset};
    assign pc_inc   = pc_reg + 12'd1;
    assign inc_word = rd_word + 12'd1;
    assign tad_sum  = {1'b0, acc_reg} + {1'b0, rd_word};
    assign opr_g2   = item.indirect && !item.page_offset[0];

    // Sequencer: dispatch, pointer fetch, autoindex, operand access, finish.
    always_comb
    begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        link_next    = link_reg;
        pc_next      = pc_reg;
        op_next      = op_reg;
        ptr_next     = ptr_reg;
        ea_next      = ea_reg;
        rd_zero_next = rd_zero_reg;
        mem_en       = 1'b0;
        mem_we       = 1'b0;
        mem_addr     = '0;
        mem_wdata    = '0;
        item_pop     = 1'b0;
        res_load     = 1'b0;
        res_skip     = 1'b0;
        res_mdata    = '0;
        opnd_go      = 1'b0;
        opnd_op      = op_reg;
        opnd_ea      = ea_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    case (item.opcode)
                        OP_AND, OP_TAD, OP_ISZ, OP_DCA, OP_JMS, OP_JMP:
                        begin
                            item_pop = 1'b1;
                            if (item.indirect)
                            begin
                                mem_en       = 1'b1;
                                mem_addr     = ptr;
                                rd_zero_next = !in_range(ptr);
                                ptr_next     = ptr;
                                op_next      = item.opcode;
                                state_next   = S_IND;
                            end
                            else
                            begin
                                opnd_go = 1'b1;
                                opnd_op = item.opcode;
                                opnd_ea = ptr;
                            end
                        end
                        OP_IOT:
                        begin
                            if (out_free)
                            begin
                                item_pop = 1'b1;
                                pc_next  = pc_inc;
                                res_load = 1'b1;
                            end
                        end
                        OP_OPR:
                        begin
                            if (out_free)
                            begin
                                item_pop = 1'b1;
                                res_skip = opr_g2 && g2_skip(item.page_offset, acc_reg, link_reg);
                                pc_next  = pc_inc + 12'(res_skip);
                                if (opr_g2 && item.current_page)
                                begin
                                    acc_next = '0;
                                end
                                res_load = 1'b1;
                            end
                        end
                        OP_DEP:
                        begin
                            if (out_free)
                            begin
                                item_pop  = 1'b1;
                                mem_en    = in_range(item.load_address);
                                mem_we    = 1'b1;
                                mem_addr  = item.load_address;
                                mem_wdata = item.load_data;
                                res_load  = 1'b1;
                            end
                        end
                        OP_SETPC:
                        begin
                            if (out_free)
                            begin
                                item_pop = 1'b1;
                                pc_next  = item.load_data;
                                res_load = 1'b1;
                            end
                        end
                        OP_EXAM:
                        begin
                            item_pop     = 1'b1;
                            mem_en       = 1'b1;
                            mem_addr     = item.load_address;
                            rd_zero_next = !in_range(item.load_address);
                            state_next   = S_EXAM;
                        end
                        default:
                        begin
                            if (out_free)
                            begin
                                item_pop = 1'b1;
                                res_load = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_IND:
            begin
                if (ptr_reg[WORD_W-1:3] == AUTO_PAGE)
                begin
                    // Autoindex: bump the pointer in memory, then use it.
                    mem_en     = in_range(ptr_reg);
                    mem_we     = 1'b1;
                    mem_addr   = ptr_reg;
                    mem_wdata  = inc_word;
                    ea_next    = inc_word;
                    state_next = S_EXEC;
                end
                else
                begin
                    opnd_go = 1'b1;
                    opnd_ea = rd_word;
                end
            end
            S_EXEC:
            begin
                opnd_go = 1'b1;
            end
            S_OPRD:
            begin
                if (out_free)
                begin
                    pc_next = pc_inc;
                    case (op_reg)
                        OP_AND:
                        begin
                            acc_next = acc_reg & rd_word;
                        end
                        OP_TAD:
                        begin
                            acc_next  = tad_sum[WORD_W-1:0];
                            link_next = link_reg ^ tad_sum[WORD_W];
                        end
                        OP_ISZ:
                        begin
                            mem_en    = in_range(ea_reg);
                            mem_we    = 1'b1;
                            mem_addr  = ea_reg;
                            mem_wdata = inc_word;
                            res_skip  = (inc_word == '0);
                            pc_next   = pc_inc + 12'(res_skip);
                        end
                        default:
                        begin
                            pc_next = pc_inc;
                        end
                    endcase
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_EXAM:
            begin
                if (out_free)
                begin
                    res_mdata  = rd_word;
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Operand access once the effective address is known.
        if (opnd_go)
        begin
            case (opnd_op)
                OP_AND, OP_TAD, OP_ISZ:
                begin
                    mem_en       = 1'b1;
                    mem_addr     = opnd_ea;
                    rd_zero_next = !in_range(opnd_ea);
                    ea_next      = opnd_ea;
                    op_next      = opnd_op;
                    state_next   = S_OPRD;
                end
                default:
                begin
                    if (out_free)
                    begin
                        case (opnd_op)
                            OP_DCA:
                            begin
                                mem_en    = in_range(opnd_ea);
                                mem_we    = 1'b1;
                                mem_addr  = opnd_ea;
                                mem_wdata = acc_reg;
                                acc_next  = '0;
                                pc_next   = pc_inc;
                            end
                            OP_JMS:
                            begin
                                mem_en    = in_range(opnd_ea);
                                mem_we    = 1'b1;
                                mem_addr  = opnd_ea;
                                mem_wdata = pc_inc;
                                pc_next   = opnd_ea + 12'd1;
                            end
                            default:
                            begin
                                pc_next = opnd_ea;
                            end
                        endcase
                        res_load   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // Result slot busy: park the resolved address.
                        ea_next    = opnd_ea;
                        op_next    = opnd_op;
                        state_next = S_EXEC;
                    end
                end
            endcase
        end
    end

    // State, architectural registers and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acc_reg       <= '0;
            link_reg      <= 1'b0;
            pc_reg        <= RESET_PC;
            op_reg        <= OP_AND;
            ptr_reg       <= '0;
            ea_reg        <= '0;
            rd_zero_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            link_reg    <= link_next;
            pc_reg      <= pc_next;
            op_reg      <= op_next;
            ptr_reg     <= ptr_next;
            ea_reg      <= ea_next;
            rd_zero_reg <= rd_zero_next;
            if (res_load)
            begin
                res_valid_reg      <= 1'b1;
                res_reg.acc_out    <= acc_next;
                res_reg.link_out   <= link_next;
                res_reg.pc_out     <= pc_next;
                res_reg.skip_taken <= res_skip;
                res_reg.mem_data   <= res_mdata;
            end
            else if (!result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

`ifndef ASSERT_OFF
    // Memory writes are issued only inside the implemented range.
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_en && mem_we) |-> in_range(mem_addr))
        else $error("mie_exec: RAM write outside the memory");

    // The pointer state always follows the cycle that issued its read.
    a_ind_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IND) |-> $past(state_reg == S_IDLE && mem_en && !mem_we))
        else $error("mie_exec: pointer state without a pointer read");

    // A skip comes only from ISZ or an operate instruction.
    a_skip_source: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && res_skip) |->
            ((state_reg == S_OPRD && op_reg == OP_ISZ) ||
             (state_reg == S_IDLE && item.opcode == OP_OPR)))
        else $error("mie_exec: skip from an instruction that cannot skip");

    // A result is loaded only into a free result register.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && result_stall) |-> !res_load)
        else $error("mie_exec: result overwritten while stalled");

    // Instructions are taken only by the dispatch state.
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |-> (state_reg == S_IDLE && item_valid))
        else $error("mie_exec: instruction taken outside dispatch");
`endif

endmodule

@@ rtl/core/minicomputer_instruction_executor.sv @@
// Channel   | Handshake                  | Beat payload
// ----------+----------------------------+---------------------------------------
// instr     | instr_valid / instr_stall  | instr_t: decoded instruction or console op
// result    | result_valid / result_stall| result_t: AC, link, PC, skip, examined word
//
// An instruction beat is held in a one-entry input buffer, so a new beat is taken
// while the previous one executes or while a finished result waits on the output.
// Execution steps are set by the single memory port: IOT, operate, deposit, set PC and
// direct DCA/JMS/JMP finish at dispatch; examine and direct AND/TAD/ISZ add an operand
// read; indirect forms add a pointer read first; autoindexing adds a pointer write-back.
// Reset clears AC and link, loads PC with octal 0200; memory contents are not cleared.
// A stalled result holds the executor at its last step; the input buffer still fills.
module minicomputer_instruction_executor
    import mie_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    instr_valid,
    output logic    instr_stall,
    input  instr_t  instr,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic   buf_valid_reg;
    instr_t buf_reg;
    logic   item_pop;

    // Input buffer: takes a beat whenever it is empty.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
            buf_reg       <= '0;
        end
        else
        begin
            if (instr_valid && !buf_valid_reg)
            begin
                buf_valid_reg <= 1'b1;
                buf_reg       <= instr;
            end
            else if (item_pop)
            begin
                buf_valid_reg <= 1'b0;
            end
        end
    end

    assign instr_stall = buf_valid_reg;

    mie_exec #(
        .MEM_WORDS (MEM_WORDS)
    ) u_exec (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (buf_valid_reg),
        .item         (buf_reg),
        .item_pop     (item_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
